>>> hw/rtl/aled_pkg.sv
// Shared types, constants and arithmetic helpers for the addressable LED PWM encoder.
package aled_pkg;

  localparam int BITS_PER_PIXEL  = 24;
  localparam int MAX_LATCH       = 40;
  localparam int DEF_LATCH_SLOTS = 40;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0]  BRIGHTNESS_RST = 8'd255;
  localparam logic [15:0] PERIOD_RST     = 16'd100;

  // Rounding offset, in percent of the period.
  localparam logic [21:0] ROUND_OFS = 22'd50;

  // Reciprocal of 100: floor(n * DIV100_MUL / 2^DIV100_SHIFT) equals n / 100
  // for every n below 2^22.
  localparam int          DIV100_SHIFT = 29;
  localparam logic [22:0] DIV100_MUL   = 23'd5368710;

  // Register indexes, decoded from address bit 2.
  typedef enum logic {
    REG_BRIGHTNESS = 1'b0,
    REG_PERIOD     = 1'b1
  } reg_idx_t;

  // Settings seen by the slot generator.
  typedef struct packed {
    logic [15:0] duty_one;
    logic [15:0] duty_zero;
  } duty_cfg_t;

  // One classified pixel waiting in the queue.
  typedef struct packed {
    logic [BITS_PER_PIXEL-1:0] grb;
    logic                      last;
  } pixel_entry_t;

  // channel * scale / 255, truncated, without a divider.
  function automatic logic [7:0] scale_ch(input logic [7:0] ch, input logic [7:0] scale);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = {8'd0, ch} * {8'd0, scale};
    sum  = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
    return sum[15:8];
  endfunction

  // (n) / 100 for n below 2^22.
  function automatic logic [15:0] div100(input logic [21:0] n);
    logic [44:0] prod;
    prod = {23'd0, n} * {22'd0, DIV100_MUL};
    return prod[DIV100_SHIFT+15:DIV100_SHIFT];
  endfunction

endpackage

>>> hw/rtl/aled_regs.sv
// Configuration registers and the derived bit-slot duty values.
module aled_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [aled_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [aled_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [aled_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output logic [7:0]                        brightness,
  output aled_pkg::duty_cfg_t               duty_cfg
);
  import aled_pkg::*;

  logic [7:0]  brightness_r, brightness_nxt;
  logic [15:0] period_r, period_nxt;
  duty_cfg_t   duty_r, duty_nxt;
  logic        wr_en;
  reg_idx_t    idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    brightness_nxt = brightness_r;
    period_nxt     = period_r;
    cfg_prdata     = '0;
    case (idx)
      REG_BRIGHTNESS: begin
        cfg_prdata = {{(CFG_DATA_W-8){1'b0}}, brightness_r};
        if (wr_en) brightness_nxt = cfg_pwdata[7:0];
      end
      REG_PERIOD: begin
        cfg_prdata = {{(CFG_DATA_W-16){1'b0}}, period_r};
        if (wr_en) period_nxt = cfg_pwdata[15:0];
      end
      default: cfg_prdata = '0;
    endcase
  end

  // Duty values are registered from the period register and follow it in the cycle after; rounding is to nearest.
  always_comb begin
    duty_nxt.duty_one  = div100({period_r, 6'd0} + ROUND_OFS);
    duty_nxt.duty_zero = div100({1'b0, period_r, 5'd0} + ROUND_OFS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHTNESS_RST;
      period_r     <= PERIOD_RST;
    end else begin
      brightness_r <= brightness_nxt;
      period_r     <= period_nxt;
    end
    duty_r <= duty_nxt;
  end

  assign brightness = brightness_r;
  assign duty_cfg   = duty_r;

endmodule

>>> hw/rtl/aled_front.sv
// Input stage: takes pixel beats, scales the channels and builds the GRB word.
module aled_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [23:0]            in_tdata,
  input  logic                   in_tlast,
  input  logic [7:0]             brightness,
  output logic                   push,
  output aled_pkg::pixel_entry_t push_data,
  input  logic                   q_full
);
  import aled_pkg::*;

  logic         fr_valid_r, fr_valid_nxt;
  pixel_entry_t fr_data_r;
  logic         take;

  assign push      = fr_valid_r & ~q_full;
  assign push_data = fr_data_r;
  assign in_tready = ~fr_valid_r | ~q_full;
  assign take      = in_tvalid & in_tready;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (take) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    if (take) begin
      fr_data_r.grb  <= {scale_ch(in_tdata[15:8], brightness),
                         scale_ch(in_tdata[7:0], brightness),
                         scale_ch(in_tdata[23:16], brightness)};
      fr_data_r.last <= in_tlast;
    end
  end

endmodule

>>> hw/rtl/aled_fifo.sv
// Small register queue between the input stage and the slot generator.
module aled_fifo #(
  parameter int DEPTH = aled_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  aled_pkg::pixel_entry_t push_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   not_empty,
  output aled_pkg::pixel_entry_t pop_data
);
  import aled_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pixel_entry_t     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  // The producer never writes into a full queue, the consumer never reads an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue read while empty");

endmodule

>>> hw/rtl/aled_back.sv
// Slot generator: turns queued pixels into one PWM compare value per cycle while the output accepts beats.
module aled_back #(
  parameter int LATCH_SLOTS = aled_pkg::DEF_LATCH_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  aled_pkg::duty_cfg_t    duty_cfg,
  input  logic                   q_not_empty,
  input  aled_pkg::pixel_entry_t q_data,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [15:0]            out_tdata,
  output logic                   out_tlast
);
  import aled_pkg::*;

  // The latch gap is capped so that a pixel never yields more than 64 slots.
  localparam int LATCH_N   = (LATCH_SLOTS > MAX_LATCH) ? MAX_LATCH : LATCH_SLOTS;
  localparam int TOTAL_MAX = BITS_PER_PIXEL + LATCH_N;
  localparam int CNT_W     = $clog2(TOTAL_MAX);
  localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(BITS_PER_PIXEL - 1);
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(TOTAL_MAX - 1);
  localparam logic [CNT_W-1:0] NUM_BITS  = CNT_W'(BITS_PER_PIXEL);

  logic                      busy_r, busy_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [BITS_PER_PIXEL-1:0] word_r, word_nxt;
  logic                      last_r, last_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic [15:0]               oduty_r, oduty_nxt;
  logic                      olast_r, olast_nxt;
  logic                      advance, final_slot;
  logic [CNT_W-1:0]          end_cnt;
  logic [15:0]               slot_duty;

  assign advance    = ~ovalid_r | out_tready;
  assign end_cnt    = last_r ? LAST_SLOT : LAST_BIT;
  assign final_slot = (cnt_r == end_cnt);
  assign slot_duty  = (cnt_r < NUM_BITS) ?
                      (word_r[BITS_PER_PIXEL-1] ? duty_cfg.duty_one : duty_cfg.duty_zero) :
                      16'd0;

  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    word_nxt   = word_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r & ~out_tready;
    oduty_nxt  = oduty_r;
    olast_nxt  = olast_r;
    pop        = 1'b0;
    if (busy_r && advance) begin
      ovalid_nxt = 1'b1;
      oduty_nxt  = slot_duty;
      olast_nxt  = final_slot;
      word_nxt   = {word_r[BITS_PER_PIXEL-2:0], 1'b0};
      cnt_nxt    = cnt_r + 1'b1;
      if (final_slot) begin
        // Chain straight into the next pixel so slots stay back to back.
        busy_nxt = q_not_empty;
        pop      = q_not_empty;
        word_nxt = q_data.grb;
        last_nxt = q_data.last;
        cnt_nxt  = '0;
      end
    end else if (!busy_r && q_not_empty) begin
      pop      = 1'b1;
      busy_nxt = 1'b1;
      word_nxt = q_data.grb;
      last_nxt = q_data.last;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
    word_r  <= word_nxt;
    last_r  <= last_nxt;
    oduty_r <= oduty_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = oduty_r;
  assign out_tlast  = olast_r;

  // Latch slots only ever follow the last pixel of a frame.
  a_latch_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r >= NUM_BITS) |-> last_r)
    else $error("latch slot for a pixel that is not last");
  // The slot counter never runs past the end of the current pixel.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r <= end_cnt))
    else $error("slot counter past end of pixel");

endmodule

>>> hw/rtl/addressable_led_pwm_encoder_unit.sv
// Top level of the addressable LED PWM bit encoder (GRB order, MSB first).
//
//  Channel | Direction | Beat contents
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | tdata[7:0] red, [15:8] green, [23:16] blue; tlast last pixel
//  out_    | master    | tdata[15:0] duty; tlast last slot of this pixel
//  cfg_    | APB slave | 0x0 brightness (8 bits), 0x4 timer period (16 bits)
//
// Each pixel produces 24 output beats, one per cycle while the output is not stalled,
// plus LATCH_SLOTS zero beats (capped at 40) after the last pixel of a frame.
// An accepted pixel passes the input register, the queue, the bit shift register
// and the slot register on its way to the output. Reset is synchronous and
// active low; it empties the pipeline and restores brightness 255 and period 100.
// Either side may stall: the queue lets the input stage keep accepting while
// the output is held, until the queue is full, and the output register holds
// its beat until taken.
module addressable_led_pwm_encoder_unit #(
  parameter int LATCH_SLOTS = aled_pkg::DEF_LATCH_SLOTS,
  parameter int QUEUE_DEPTH = aled_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Pixel input.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // red, green, blue from bit 0 up
  input  logic                            in_tlast,
  // Slot output.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // duty
  output logic                            out_tlast,
  // Register access.
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [aled_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [aled_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [aled_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import aled_pkg::*;

  logic         [7:0] brightness;
  duty_cfg_t          duty_cfg;
  logic               push, q_full, q_pop, q_not_empty;
  pixel_entry_t       push_data, q_data;

  // Register file; it also precomputes the compare values for one and zero bits
  // so that the slot generator only has to select between them.
  aled_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .brightness  (brightness),
    .duty_cfg    (duty_cfg)
  );

  // Front: scales each channel by brightness/255 and reorders to GRB.
  aled_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .brightness (brightness),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  // Queue that decouples pixel intake from slot generation.
  aled_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  // Back: serializes 24 bits per pixel and appends the latch gap after the last pixel of a frame.
  aled_back #(
    .LATCH_SLOTS (LATCH_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .duty_cfg    (duty_cfg),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .pop         (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

>>> verif/tb_addressable_led_pwm_encoder_unit.sv
// Self-checking testbench for the addressable LED PWM bit encoder: pixels in, duty slots out.
module tb_addressable_led_pwm_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import aled_pkg::*;

  // The latch gap after the last pixel of a frame; the instance gets the same value.
  localparam int LATCH       = 40;
  // Cycles allowed after the last slot before the block counts as idle.
  localparam int SETTLE      = 8;
  // Cycles with no beat on any port before the run is declared hung.
  localparam int HANG_LIMIT  = 2000;

  // One expected output beat: the compare value and the end-of-pixel flag.
  typedef struct packed {
    logic [15:0] duty;
    logic        last;
  } slot_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;   // red, green, blue from bit 0 up
  logic                  in_tlast = 1'b0; // last pixel of the frame
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;       // duty
  logic                  out_tlast;       // last slot caused by this pixel
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Our own copy of the two registers, updated as each write completes.
  logic [7:0]  bright_q = BRIGHTNESS_RST;
  logic [15:0] period_q = PERIOD_RST;

  // Slots predicted for accepted pixels, oldest first.
  slot_t pending_slots[$];

  // Idling percentages for the current phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int errors = 0;
  int pixels_sent = 0;
  int frames_sent = 0;
  int slots_checked = 0;
  int settings_used = 0;

  addressable_led_pwm_encoder_unit #(
    .LATCH_SLOTS(LATCH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // The receiver holds off at random according to the current phase. Only one
  // assignment per edge, so the ready value never depends on event order.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every mismatch goes through here: one line each, and the count decides the verdict.
  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    errors++;
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Channel scaling: value times brightness over 255, truncated.
  function automatic logic [7:0] dim_channel(input logic [7:0] ch);
    int unsigned prod;
    prod = 32'(ch) * 32'(bright_q);
    return 8'(prod / 255);
  endfunction

  // Compare value for one data bit: 64% of the period for a one, 32% for a
  // zero, rounded to the nearest tick.
  function automatic logic [15:0] bit_compare(input bit one);
    int unsigned p;
    int unsigned d;
    p = period_q;
    d = one ? (p * 64 + 50) / 100 : (p * 32 + 50) / 100;
    return d[15:0];
  endfunction

  // Work out every slot a pixel causes and queue them behind the earlier ones.
  // Bits go out green, red, blue with the most significant bit first; the
  // last pixel of a frame is followed by the all-zero latch gap.
  function automatic void predict_pixel_slots(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic last);
    logic [23:0] grb;
    logic [15:0] d_one;
    logic [15:0] d_zero;
    int          total;
    slot_t       s;
    grb    = {dim_channel(g), dim_channel(r), dim_channel(b)};
    d_one  = bit_compare(1'b1);
    d_zero = bit_compare(1'b0);
    total  = BITS_PER_PIXEL + (last ? LATCH : 0);
    for (int i = 0; i < BITS_PER_PIXEL; i++) begin
      s.duty = grb[BITS_PER_PIXEL-1-i] ? d_one : d_zero;
      s.last = (i + 1 == total);
      pending_slots.push_back(s);
    end
    if (last) begin
      for (int i = 0; i < LATCH; i++) begin
        s.duty = '0;
        s.last = (BITS_PER_PIXEL + i + 1 == total);
        pending_slots.push_back(s);
      end
    end
  endfunction

  // Slot checker: every accepted output beat is matched against the oldest
  // prediction. A beat with nothing pending is an error on its own.
  always @(posedge clk) begin : check_slots
    slot_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_slots.size() == 0) begin
        report_mismatch("unexpected slot, pending count", 0, 32'(out_tdata));
      end else begin
        want = pending_slots.pop_front();
        slots_checked++;
        if (out_tdata !== want.duty)
          report_mismatch("duty", 32'(want.duty), 32'(out_tdata));
        if (out_tlast !== want.last)
          report_mismatch("last slot flag", 32'(want.last), 32'(out_tlast));
      end
    end
  end

  // Watchdog: counts cycles with no beat on any port. Drains, register
  // accesses and stalls all keep something moving, so a long silence is a hang.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) quiet = 0;
      else quiet++;
      if (quiet >= HANG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d slots still pending",
                 quiet, pending_slots.size());
        $display("** addressable_led_pwm_encoder_unit: FAILED **");
        $finish;
      end
    end
  end

  // Offer one pixel, with random idle cycles in front of it per the current
  // phase. The task returns at the edge where the beat is taken and leaves
  // tvalid high, so back-to-back pixels never see a low-then-high glitch;
  // whoever does something else next lowers it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_pixel_slots(r, g, b, last);
    pixels_sent++;
    if (last) frames_sent++;
  endtask

  // Stop offering pixels and wait until every predicted slot has come out,
  // then give the pipeline the SETTLE margin to go quiet.
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register read: setup cycle, then the access cycle, sampled when pready is up.
  task automatic read_reg(input reg_idx_t idx, output logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    value = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Compare a register's read-back value with our copy, on its own width.
  task automatic check_reg(input reg_idx_t idx);
    logic [31:0] rd;
    read_reg(idx, rd);
    if (idx == REG_BRIGHTNESS) begin
      if (rd[7:0] !== bright_q)
        report_mismatch("brightness read-back", 32'(bright_q), 32'(rd[7:0]));
    end else begin
      if (rd[15:0] !== period_q)
        report_mismatch("period read-back", 32'(period_q), 32'(rd[15:0]));
    end
  endtask

  // Register write, only once the block has gone idle. The copy is updated
  // after the access edge and then read back.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    wait_until_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_BRIGHTNESS) bright_q = value[7:0];
    else period_q = value[15:0];
    check_reg(idx);
  endtask

  task automatic set_levels(input logic [7:0] bright, input logic [15:0] period);
    write_reg(REG_BRIGHTNESS, {24'd0, bright});
    write_reg(REG_PERIOD, {16'd0, period});
    settings_used++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // The registers come out of reset at full brightness and a 100-tick period,
  // and pixels sent right away use those values.
  task automatic test_reset_values();
    check_reg(REG_BRIGHTNESS);
    check_reg(REG_PERIOD);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'h0F, 1'b0);
    send_pixel(8'h80, 8'h01, 8'h7E, 1'b1);
    wait_until_drained();
  endtask

  // Extremes of both registers: zero brightness turns every bit into a zero
  // bit, a brightness of one keeps only full channels, a zero period makes
  // both compare values zero, and the largest period checks the widest
  // rounding arithmetic.
  task automatic test_register_extremes();
    set_levels(8'd0, PERIOD_RST);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h12, 8'h34, 8'h56, 1'b0);
    set_levels(8'd1, 16'd1);
    send_pixel(8'hFF, 8'hFE, 8'h80, 1'b1);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    set_levels(8'd128, 16'd0);
    send_pixel(8'hFF, 8'hC8, 8'h03, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
    set_levels(8'd255, 16'd65535);
    send_pixel(8'hA5, 8'h5A, 8'hFF, 1'b1);
    send_pixel(8'h01, 8'h80, 8'h00, 1'b0);
    set_levels(8'd254, 16'd2);
    send_pixel(8'hFF, 8'hFF, 8'h7F, 1'b1);
    set_levels(BRIGHTNESS_RST, PERIOD_RST);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b1);
    wait_until_drained();
  endtask

  // Random frames of one to six pixels, the last one flagged, with random
  // colors. Between frames the registers sometimes move, often to an extreme.
  task automatic test_random_frames(input int n_pixels);
    int          sent;
    int          len;
    logic [7:0]  bright;
    logic [15:0] period;
    sent = 0;
    while (sent < n_pixels) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), (i == len - 1));
      end
      sent += len;
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: bright = 8'd0;
          1: bright = 8'd255;
          default: bright = 8'($urandom_range(255));
        endcase
        case ($urandom_range(4))
          0: period = 16'd1;
          1: period = 16'd65535;
          2: period = PERIOD_RST;
          default: period = 16'($urandom_range(1, 65535));
        endcase
        set_levels(bright, period);
      end
    end
    wait_until_drained();
  endtask

  // The sender stops after each frame until every slot of it has come out,
  // so the block runs fully empty between frames.
  task automatic test_drain_between_frames();
    for (int f = 0; f < 4; f++) begin
      for (int i = 0; i < 3; i++) begin
        send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), (i == 2));
      end
      wait_until_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 0);
    test_reset_values();
    test_register_extremes();

    // Four idling phases: none, sender only, receiver only, both lightly.
    set_idling(0, 0);
    test_random_frames(75);
    set_idling(55, 0);
    test_random_frames(75);
    set_idling(0, 55);
    test_random_frames(75);
    set_idling(11, 11);
    test_random_frames(75);

    set_idling(11, 55);
    test_drain_between_frames();

    // Everything has drained; leave a short window for any stray beat.
    set_idling(0, 0);
    wait_until_drained();
    repeat (4 * SETTLE) @(posedge clk);

    $display("Covered %0d pixels in %0d frames, %0d slots checked, %0d register settings",
             pixels_sent, frames_sent, slots_checked, settings_used);
    $display("including zero and full brightness, zero and maximum period, four idling phases.");
    if (errors == 0) begin
      $display("** addressable_led_pwm_encoder_unit: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** addressable_led_pwm_encoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
